FILE: sv/gce_pkg.sv
// shared types and constants of the glyph color expander
package gce_pkg;

  // configuration register map
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    REG_FRAME_BASE  = 2'd0,
    REG_LINE_WIDTH  = 2'd1,
    REG_GLYPH_WIDTH = 2'd2
  } gce_reg_e;

  // register widths and reset values
  localparam int unsigned FrameBaseW  = 32;
  localparam int unsigned LineWidthW  = 13;
  localparam int unsigned GlyphWidthW = 5;

  localparam logic [FrameBaseW-1:0]  FrameBaseRst  = 32'h0000_0000;
  localparam logic [LineWidthW-1:0]  LineWidthRst  = 13'd1024;
  localparam logic [GlyphWidthW-1:0] GlyphWidthRst = 5'd8;

  // field widths
  localparam int unsigned CoordW = 12;
  localparam int unsigned RowW   = 6;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned ColorW = 24;
  localparam int unsigned AddrW  = 32;

  // row number on screen and row start in pixels
  localparam int unsigned LineW  = 13;
  localparam int unsigned ProdW  = LineWidthW + LineW;

  localparam logic [AddrW-1:0] BytesPerPixel = 32'd3;

  // one classified row waiting for expansion
  typedef struct packed {
    logic [AddrW-1:0]       byte_address;
    logic [MaskW-1:0]       row_mask;
    logic [ColorW-1:0]      fore_color;
    logic [ColorW-1:0]      back_color;
    logic                   glyph_end;
    logic [GlyphWidthW-1:0] glyph_width;
  } gce_entry_t;

endpackage

FILE: sv/gce_if.sv
// row input and pixel output channel interfaces

interface gce_row_if;
  logic                         valid;
  logic                         ready;
  logic [gce_pkg::CoordW-1:0]   origin_x;
  logic [gce_pkg::CoordW-1:0]   origin_y;
  logic [gce_pkg::RowW-1:0]     row_index;
  logic [gce_pkg::MaskW-1:0]    row_mask;
  logic [gce_pkg::ColorW-1:0]   fore_color;
  logic [gce_pkg::ColorW-1:0]   back_color;
  logic                         glyph_end;

  modport source (
    output valid, origin_x, origin_y, row_index, row_mask, fore_color, back_color, glyph_end,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, row_index, row_mask, fore_color, back_color, glyph_end,
    output ready
  );
endinterface

interface gce_pix_if;
  logic                         valid;
  logic                         ready;
  logic [gce_pkg::AddrW-1:0]    byte_address;
  logic [gce_pkg::ColorW-1:0]   pixel_color;
  logic                         row_last;
  logic                         glyph_done;

  modport source (
    output valid, byte_address, pixel_color, row_last, glyph_done,
    input  ready
  );
  modport sink (
    input  valid, byte_address, pixel_color, row_last, glyph_done,
    output ready
  );
endinterface

FILE: sv/gce_front.sv
// front end: takes rows, forms the row start address, pushes to the queue
module gce_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  gce_row_if.sink                             in_i,
  input  logic [gce_pkg::FrameBaseW-1:0]      frame_base_i,
  input  logic [gce_pkg::LineWidthW-1:0]      line_width_i,
  input  logic [gce_pkg::GlyphWidthW-1:0]     glyph_width_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output gce_pkg::gce_entry_t                 push_entry_o
);
  import gce_pkg::*;

  logic                 valid_q, valid_d;
  logic [ProdW-1:0]     prod_q;
  logic [CoordW-1:0]    ox_q;
  logic [MaskW-1:0]     mask_q;
  logic [ColorW-1:0]    fore_q;
  logic [ColorW-1:0]    back_q;
  logic                 end_q;
  logic [LineW-1:0]     line_num;
  logic                 in_fire;
  logic [ProdW:0]       pix0;
  logic [AddrW-1:0]     pix0_bytes;

  // stage holds one row; it frees as soon as the queue takes it
  assign in_i.ready = !valid_q || push_ready_i;
  assign in_fire    = in_i.valid && in_i.ready;

  // screen row of this glyph row
  assign line_num = LineW'(in_i.origin_y) + LineW'(in_i.row_index);

  // stage valid
  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // row stride multiply, registered
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prod_q <= ProdW'(line_width_i) * ProdW'(line_num);
      ox_q   <= in_i.origin_x;
      mask_q <= in_i.row_mask;
      fore_q <= in_i.fore_color;
      back_q <= in_i.back_color;
      end_q  <= in_i.glyph_end;
    end
  end

  // first pixel address: base + pixel index times three, modulo 2^32
  assign pix0       = (ProdW+1)'(prod_q) + (ProdW+1)'(ox_q);
  assign pix0_bytes = AddrW'(pix0) * BytesPerPixel;

  assign push_valid_o              = valid_q;
  assign push_entry_o.byte_address = frame_base_i + pix0_bytes;
  assign push_entry_o.row_mask     = mask_q;
  assign push_entry_o.fore_color   = fore_q;
  assign push_entry_o.back_color   = back_q;
  assign push_entry_o.glyph_end    = end_q;
  assign push_entry_o.glyph_width  = glyph_width_i;

endmodule

FILE: sv/gce_fifo.sv
// short queue of classified rows between front and back end
module gce_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  gce_pkg::gce_entry_t  push_entry_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output gce_pkg::gce_entry_t  pop_entry_o
);
  import gce_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  gce_entry_t          mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: sv/gce_back.sv
// back end: expands one queued row into one pixel beat per cycle while out_o is ready
module gce_back #(
  parameter int unsigned MAX_GLYPH_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  gce_pkg::gce_entry_t  pop_entry_i,
  gce_pix_if.source            out_o
);
  import gce_pkg::*;

  localparam int unsigned WW = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int unsigned MW = (MAX_GLYPH_WIDTH > MaskW) ? MAX_GLYPH_WIDTH : MaskW;
  localparam int unsigned CW = (WW > GlyphWidthW) ? WW : GlyphWidthW;

  logic                        busy_q, busy_d;
  logic [AddrW-1:0]            addr_q;
  logic [MAX_GLYPH_WIDTH-1:0]  mask_q;
  logic [WW-1:0]               cnt_q;
  logic [ColorW-1:0]           fore_q;
  logic [ColorW-1:0]           back_q;
  logic                        end_q;

  logic                        last;
  logic                        out_fire;
  logic                        load;
  logic [CW-1:0]               gw_ext;
  logic [WW-1:0]               eff_w;
  logic [MW-1:0]               mask_ext;
  logic [MAX_GLYPH_WIDTH-1:0]  mask_aligned;

  assign last     = (cnt_q == WW'(1));
  assign out_fire = out_o.valid && out_o.ready;

  // take the next row when idle or when the last pixel of this row leaves
  assign pop_ready_o = !busy_q || (out_o.ready && last);
  assign load        = pop_valid_i && pop_ready_o;

  // clamp the glyph width to one..max
  assign gw_ext = CW'(pop_entry_i.glyph_width);
  always_comb begin
    if (gw_ext == '0) begin
      eff_w = WW'(1);
    end else if (gw_ext > CW'(MAX_GLYPH_WIDTH)) begin
      eff_w = WW'(MAX_GLYPH_WIDTH);
    end else begin
      eff_w = WW'(gw_ext);
    end
  end

  // leftmost pixel's bit moved to the top of the shift register
  assign mask_ext     = MW'(pop_entry_i.row_mask);
  assign mask_aligned = mask_ext[MAX_GLYPH_WIDTH-1:0] << (WW'(MAX_GLYPH_WIDTH) - eff_w);

  // busy flag
  always_comb begin
    busy_d = busy_q;
    if (load) begin
      busy_d = 1'b1;
    end else if (out_fire && last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // per pixel stepping
  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q <= pop_entry_i.byte_address;
      mask_q <= mask_aligned;
      cnt_q  <= eff_w;
      fore_q <= pop_entry_i.fore_color;
      back_q <= pop_entry_i.back_color;
      end_q  <= pop_entry_i.glyph_end;
    end else if (out_fire) begin
      addr_q <= addr_q + BytesPerPixel;
      mask_q <= mask_q << 1;
      cnt_q  <= cnt_q - 1'b1;
    end
  end

  // pixel beat
  assign out_o.valid        = busy_q;
  assign out_o.byte_address = addr_q;
  assign out_o.pixel_color  = mask_q[MAX_GLYPH_WIDTH-1] ? fore_q : back_q;
  assign out_o.row_last     = last;
  assign out_o.glyph_done   = last && end_q;

endmodule

FILE: sv/glyph_color_expander_unit.sv
// top level of the glyph color expander: registers, front, queue, back
//
// Usage: each beat on in_i describes one glyph row (origin, row index, row
// mask, foreground and background colors, glyph end flag). The block emits
// one beat on out_o per glyph column, leftmost first, carrying the byte
// address of the pixel's first byte, the chosen color, a row-last flag and
// the glyph end flag on the row's last pixel.
// Registers frame_base (0x0), line_width (0x4) and glyph_width (0x8) are
// written over the APB port; write them only while the block is idle.
// The first pixel of a row leaves after the stride multiply register, the
// queue and the expander's registers.
// The expander emits one pixel per cycle while out_o.ready is high; a row has
// its clamped glyph width in pixels (1 to MAX_GLYPH_WIDTH; eight at reset).
// Consecutive rows leave without gaps when the next row is already queued.
// A two-entry queue lets the front keep taking rows while out_o stalls;
// once it and the front stage fill, in_i.ready drops until a row drains.
// Reset empties the pipeline and loads base 0, line width 1024, width 8.
module glyph_color_expander_unit #(
  parameter int unsigned MAX_GLYPH_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gce_row_if.sink                           in_i,
  gce_pix_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gce_pkg::CfgAddrW-1:0]      paddr,
  input  logic [gce_pkg::CfgDataW-1:0]      pwdata,
  output logic [gce_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready
);
  import gce_pkg::*;

  localparam int unsigned QueueDepth = 2;

  logic [FrameBaseW-1:0]   frame_base_q;
  logic [LineWidthW-1:0]   line_width_q;
  logic [GlyphWidthW-1:0]  glyph_width_q;
  logic                    cfg_write;
  gce_reg_e                reg_sel;

  logic                    push_valid, push_ready;
  gce_entry_t              push_entry;
  logic                    pop_valid, pop_ready;
  gce_entry_t              pop_entry;

  // register access
  assign pready    = 1'b1;
  assign reg_sel   = gce_reg_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q  <= FrameBaseRst;
      line_width_q  <= LineWidthRst;
      glyph_width_q <= GlyphWidthRst;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FRAME_BASE:  frame_base_q  <= pwdata[FrameBaseW-1:0];
        REG_LINE_WIDTH:  line_width_q  <= pwdata[LineWidthW-1:0];
        REG_GLYPH_WIDTH: glyph_width_q <= pwdata[GlyphWidthW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      REG_FRAME_BASE:  prdata = CfgDataW'(frame_base_q);
      REG_LINE_WIDTH:  prdata = CfgDataW'(line_width_q);
      REG_GLYPH_WIDTH: prdata = CfgDataW'(glyph_width_q);
      default:         prdata = '0;
    endcase
  end

  // row intake and address setup
  gce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .frame_base_i  (frame_base_q),
    .line_width_i  (line_width_q),
    .glyph_width_i (glyph_width_q),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  // row queue
  gce_fifo #(
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // pixel expansion
  gce_back #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

  // glyph end only ever shows on a row's last pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.glyph_done |-> out_o.row_last)
    else $error("glyph_done without row_last");

  // pixels of one row leave without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.row_last |=> out_o.valid)
    else $error("gap inside a row");

  // consecutive pixels of a row are three bytes apart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.row_last
    |=> out_o.byte_address == $past(out_o.byte_address) + BytesPerPixel)
    else $error("pixel address step is not three bytes");

  // while the queue is full, a front stage that held a row takes no new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready |-> !(in_i.valid && in_i.ready && !$past(in_i.ready)))
    else $error("row accepted while queue full and front stage held");

endmodule
